### sv/mwsum_pkg.sv
`timescale 1ns / 1ps

package mwsum_pkg;

  // Sizing
  localparam int MAX_WINDOW   = 1024;
  localparam int SAMPLE_WIDTH = 32;
  localparam int SUM_WIDTH    = 42;
  localparam int LEN_WIDTH    = 11;
  localparam int PTR_WIDTH    = $clog2(MAX_WINDOW);
  localparam int WIN_WIDTH    = $clog2(MAX_WINDOW + 1);
  localparam int RING_WIDTH   = SAMPLE_WIDTH + 1;
  localparam int CMP_WIDTH    = (LEN_WIDTH > WIN_WIDTH) ? LEN_WIDTH : WIN_WIDTH;

  // Configuration register map
  localparam int CFG_INDEX_WIDTH = 2;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  localparam cfg_index_t REG_WINDOW_LENGTH = cfg_index_t'(0);
  localparam cfg_index_t REG_MIN_VALID     = cfg_index_t'(1);

  // One sample in flight between the ring stage and the accumulator
  typedef struct packed {
    logic                           row_clear;
    logic                           evict;
    logic                           sample_valid;
    logic signed [SAMPLE_WIDTH-1:0] sample;
  } stage_t;

endpackage

### sv/mwsum_ram.sv
`timescale 1ns / 1ps

module mwsum_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### sv/mwsum_ring.sv
`timescale 1ns / 1ps

module mwsum_ring import mwsum_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           sample_valid,
  input  logic                           row_start,
  input  logic [LEN_WIDTH-1:0]           window_length,
  input  logic                           cfg_clear,
  input  logic                           stage_adv,
  output logic                           stage_valid,
  output stage_t                         stage,
  output logic [RING_WIDTH-1:0]          ring_rd_data
);

  logic [PTR_WIDTH-1:0]   ring_pointer;
  logic [PTR_WIDTH-1:0]   ring_pointer_next;
  logic [WIN_WIDTH-1:0]   fill_level;
  logic [WIN_WIDTH-1:0]   fill_base;
  logic [WIN_WIDTH-1:0]   fill_level_next;
  logic [WIN_WIDTH-1:0]   win;
  logic [WIN_WIDTH:0]     rd_offset;
  logic [PTR_WIDTH-1:0]   rd_addr;
  logic                   evict;

  // Effective window: zero acts as one, clamp to ring depth
  always_comb begin
    if (window_length == '0) begin
      win = WIN_WIDTH'(1);
    end else if (CMP_WIDTH'(window_length) > CMP_WIDTH'(MAX_WINDOW)) begin
      win = WIN_WIDTH'(MAX_WINDOW);
    end else begin
      win = WIN_WIDTH'(window_length);
    end
  end

  // Fill tracking and eviction decision
  always_comb begin
    fill_base       = row_start ? '0 : fill_level;
    evict           = (fill_base >= win);
    fill_level_next = evict ? fill_base : fill_base + WIN_WIDTH'(1);
  end

  // Slot leaving the window: pointer minus window, modulo ring depth
  always_comb begin
    rd_offset = (WIN_WIDTH+1)'(ring_pointer) + (WIN_WIDTH+1)'(MAX_WINDOW)
                - (WIN_WIDTH+1)'(win);
    if (rd_offset >= (WIN_WIDTH+1)'(MAX_WINDOW)) begin
      rd_offset = rd_offset - (WIN_WIDTH+1)'(MAX_WINDOW);
    end
    rd_addr = PTR_WIDTH'(rd_offset);
    if (ring_pointer == PTR_WIDTH'(MAX_WINDOW - 1)) begin
      ring_pointer_next = '0;
    end else begin
      ring_pointer_next = ring_pointer + PTR_WIDTH'(1);
    end
  end

  // Pointer, fill and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pointer <= '0;
      fill_level   <= '0;
      stage_valid  <= 1'b0;
    end else begin
      if (cfg_clear) begin
        fill_level <= '0;
      end else if (accept) begin
        fill_level <= fill_level_next;
      end
      if (accept) begin
        ring_pointer <= ring_pointer_next;
        stage_valid  <= 1'b1;
      end else if (stage_adv) begin
        stage_valid  <= 1'b0;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      stage.row_clear    <= row_start;
      stage.evict        <= evict;
      stage.sample_valid <= sample_valid;
      stage.sample       <= sample;
    end
  end

  // Sample ring: write the new sample, read the one leaving
  mwsum_ram #(
    .WIDTH (RING_WIDTH),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (ring_pointer),
    .wr_data ({sample_valid, sample}),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (ring_rd_data)
  );

endmodule

### sv/mwsum_accum.sv
`timescale 1ns / 1ps

module mwsum_accum import mwsum_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        stage_valid,
  input  stage_t                      stage,
  input  logic [RING_WIDTH-1:0]       ring_rd_data,
  input  logic [LEN_WIDTH-1:0]        min_valid,
  input  logic                        cfg_clear,
  input  logic                        out_stall,
  output logic                        stage_adv,
  output logic                        out_valid,
  output logic signed [SUM_WIDTH-1:0] window_sum,
  output logic                        sum_valid
);

  logic signed [SUM_WIDTH-1:0] running_sum;
  logic signed [SUM_WIDTH-1:0] running_sum_next;
  logic signed [SUM_WIDTH-1:0] sum_base;
  logic signed [SUM_WIDTH-1:0] old_ext;
  logic signed [SUM_WIDTH-1:0] new_ext;
  logic [WIN_WIDTH-1:0]        valid_count;
  logic [WIN_WIDTH-1:0]        valid_count_next;
  logic [WIN_WIDTH-1:0]        count_base;
  logic [LEN_WIDTH-1:0]        min_eff;
  logic                        old_used;
  logic                        count_dec;
  logic                        sum_valid_next;

  // Stage moves on when the output register is free or being drained
  assign stage_adv = stage_valid && (!out_valid || !out_stall);

  // Remove the evicted sample, add the new one
  always_comb begin
    sum_base   = stage.row_clear ? '0 : running_sum;
    count_base = stage.row_clear ? '0 : valid_count;
    old_used   = stage.evict && ring_rd_data[SAMPLE_WIDTH];
    old_ext    = {{(SUM_WIDTH-SAMPLE_WIDTH){ring_rd_data[SAMPLE_WIDTH-1]}},
                  ring_rd_data[SAMPLE_WIDTH-1:0]};
    new_ext    = {{(SUM_WIDTH-SAMPLE_WIDTH){stage.sample[SAMPLE_WIDTH-1]}},
                  stage.sample};
    running_sum_next = sum_base - (old_used ? old_ext : '0)
                       + (stage.sample_valid ? new_ext : '0);
    count_dec  = old_used && (count_base != '0);
    valid_count_next = count_base - WIN_WIDTH'(count_dec)
                       + WIN_WIDTH'(stage.sample_valid);
    min_eff    = (min_valid == '0) ? LEN_WIDTH'(1) : min_valid;
    sum_valid_next = (CMP_WIDTH'(valid_count_next) >= CMP_WIDTH'(min_eff));
  end

  // Accumulator state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      valid_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_clear) begin
        running_sum <= '0;
        valid_count <= '0;
      end else if (stage_adv) begin
        running_sum <= running_sum_next;
        valid_count <= valid_count_next;
      end
      if (stage_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (stage_adv) begin
      window_sum <= running_sum_next;
      sum_valid  <= sum_valid_next;
    end
  end

endmodule

### sv/moving_window_sum_nan_skip.sv
`timescale 1ns / 1ps
// A sample accepted into the stage register (ring read stage) moves on to the
// result register when that register is free or being drained.
// Throughput: one sample per cycle while out_stall is low, set by the single ring
// read port (eviction read issued at accept) and the add/subtract accumulator.
// Reset (synchronous, rst high): clears pointer, fill, sum, count and valids;
// window_length and min_valid return to 1. Ring contents are not cleared.
module moving_window_sum_nan_skip import mwsum_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           sample_valid,
  input  logic                           row_start,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SUM_WIDTH-1:0]    window_sum,
  output logic                           sum_valid,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  cfg_index_t                     cfg_index,
  input  logic [LEN_WIDTH-1:0]           cfg_data
);

  logic [LEN_WIDTH-1:0]  window_length;
  logic [LEN_WIDTH-1:0]  min_valid;
  logic                  cfg_write;
  logic                  cfg_clear;
  logic                  accept;
  logic                  stage_valid;
  logic                  stage_adv;
  stage_t                stage;
  logic [RING_WIDTH-1:0] ring_rd_data;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_write && (cfg_index == REG_WINDOW_LENGTH);
  assign in_stall  = stage_valid && !stage_adv;
  assign accept    = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_WIDTH'(1);
      min_valid     <= LEN_WIDTH'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data;
        REG_MIN_VALID:     min_valid     <= cfg_data;
        default: ;
      endcase
    end
  end

  mwsum_ring u_ring (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample        (sample),
    .sample_valid  (sample_valid),
    .row_start     (row_start),
    .window_length (window_length),
    .cfg_clear     (cfg_clear),
    .stage_adv     (stage_adv),
    .stage_valid   (stage_valid),
    .stage         (stage),
    .ring_rd_data  (ring_rd_data)
  );

  mwsum_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .stage_valid  (stage_valid),
    .stage        (stage),
    .ring_rd_data (ring_rd_data),
    .min_valid    (min_valid),
    .cfg_clear    (cfg_clear),
    .out_stall    (out_stall),
    .stage_adv    (stage_adv),
    .out_valid    (out_valid),
    .window_sum   (window_sum),
    .sum_valid    (sum_valid)
  );

  // Input backpressure only comes from a blocked result register
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result path is free");

  // A held stage item is still there next cycle
  assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !stage_adv) |=> stage_valid)
    else $error("stage item dropped while stalled");

  // Every accepted sample reaches the stage register
  assert property (@(posedge clk) disable iff (rst)
    accept |=> stage_valid)
    else $error("accepted sample missing from stage");

  // A stage item that advances shows up as a result
  assert property (@(posedge clk) disable iff (rst)
    stage_adv |=> out_valid)
    else $error("advanced item missing from output");

endmodule

### verif/mwsum_checker.sv
`timescale 1ns / 1ps
module mwsum_checker import mwsum_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           sample_valid,
  input  logic                           row_start,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [SUM_WIDTH-1:0]    window_sum,
  input  logic                           sum_valid,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  cfg_index_t                     cfg_index,
  input  logic [LEN_WIDTH-1:0]           cfg_data,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic                           ok;
    logic signed [SAMPLE_WIDTH-1:0] val;
  } slot_t;

  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] total;
    logic                        flag;
  } window_result_t;

  // Predicted window state
  slot_t                       hist [MAX_WINDOW];
  logic signed [SUM_WIDTH-1:0] acc_sum;
  logic [LEN_WIDTH-1:0]        acc_count;
  logic [LEN_WIDTH-1:0]        fill;
  logic [LEN_WIDTH-1:0]        win_len;
  logic [LEN_WIDTH-1:0]        min_cnt;
  logic [PTR_WIDTH-1:0]        wr_ptr;
  window_result_t              sums_due [$];
  int                          err_cnt = 0;

  assign fail_count = err_cnt;

  // Row start and window rewrite both drop the current row
  function automatic void clear_row();
    acc_sum   = '0;
    acc_count = '0;
    fill      = '0;
  endfunction

  // Take one sample into the window and return the sum it produces
  function automatic window_result_t advance_window(
    input logic signed [SAMPLE_WIDTH-1:0] s,
    input logic                           ok,
    input logic                           first
  );
    int                          span;
    logic [LEN_WIDTH-1:0]        need;
    logic [PTR_WIDTH-1:0]        old_ptr;
    logic signed [SUM_WIDTH-1:0] ext;
    window_result_t              r;
    if (first) clear_row();
    // out-of-range window lengths clamp to 1..MAX_WINDOW
    span = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len));
    if (fill >= span) begin
      old_ptr = wr_ptr - PTR_WIDTH'(span);
      if (hist[old_ptr].ok) begin
        ext     = hist[old_ptr].val;
        acc_sum = acc_sum - ext;
        if (acc_count != 0) acc_count = acc_count - 1'b1;
      end
    end else begin
      fill = fill + 1'b1;
    end
    hist[wr_ptr] = '{ok, s};
    // missing samples hold a slot but add nothing
    if (ok) begin
      ext       = s;
      acc_sum   = acc_sum + ext;
      acc_count = acc_count + 1'b1;
    end
    wr_ptr = wr_ptr + 1'b1;
    need    = (min_cnt == 0) ? LEN_WIDTH'(1) : min_cnt;
    r.total = acc_sum;
    r.flag  = (acc_count >= need);
    return r;
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      clear_row();
      wr_ptr  = '0;
      win_len = LEN_WIDTH'(1);
      min_cnt = LEN_WIDTH'(1);
      sums_due.delete();
    end else begin
      // result transaction against the oldest prediction
      if (out_valid && !out_stall) begin
        if (sums_due.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: window_sum %0d sum_valid %0b",
                   $time, window_sum, sum_valid);
        end else begin
          want = sums_due.pop_front();
          if (window_sum !== want.total) begin
            err_cnt++;
            $display("%0t: window_sum mismatch: expected %0d, actual %0d",
                     $time, $signed(want.total), window_sum);
          end
          if (sum_valid !== want.flag) begin
            err_cnt++;
            $display("%0t: sum_valid mismatch: expected %0b, actual %0b",
                     $time, want.flag, sum_valid);
          end
        end
      end
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: begin
            win_len = cfg_data;
            clear_row();
          end
          REG_MIN_VALID: min_cnt = cfg_data;
          default: ;
        endcase
      end
      // sample transaction
      if (in_valid && !in_stall)
        sums_due.push_back(advance_window(sample, sample_valid, row_start));
    end
    pending <= sums_due.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mwsum_pkg::*;

  // indexes outside the register map, writes must be ignored
  localparam cfg_index_t REG_SPARE_2 = cfg_index_t'(2);
  localparam cfg_index_t REG_SPARE_3 = cfg_index_t'(3);
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 240;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           sample_valid;
  logic                           row_start;
  logic                           out_valid;
  logic                           out_stall;
  logic signed [SUM_WIDTH-1:0]    window_sum;
  logic                           sum_valid;
  logic                           cfg_valid;
  logic                           cfg_ready;
  cfg_index_t                     cfg_index;
  logic [LEN_WIDTH-1:0]           cfg_data;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int cur_win = 1;
  bit src_gaps = 1;
  bit snk_stalls = 1;
  bit hold_req = 0;

  moving_window_sum_nan_skip dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .sample_valid (sample_valid),
    .row_start    (row_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_sum   (window_sum),
    .sum_valid    (sum_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mwsum_checker sum_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .sample_valid (sample_valid),
    .row_start    (row_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_sum   (window_sum),
    .sum_valid    (sum_valid),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (snk_stalls && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Watchdog: too long with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[moving_window_sum_nan_skip] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return SAMPLE_WIDTH'($urandom_range(0, 40)) - SAMPLE_WIDTH'(20);
      default: return $urandom;
    endcase
  endfunction

  function automatic int span_of(input int w);
    return (w == 0) ? 1 : ((w > MAX_WINDOW) ? MAX_WINDOW : w);
  endfunction

  // One sample transaction, with an optional gap before it
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s,
                             input logic ok, input logic first);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample       <= s;
    sample_valid <= ok;
    row_start    <= first;
    do @(posedge clk); while (in_stall);
  endtask

  // Leaves cfg_valid high so back-to-back writes need one assignment per edge
  task automatic write_reg(input cfg_index_t idx, input logic [LEN_WIDTH-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_WINDOW_LENGTH) cur_win = int'(val);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input int w, input int mc);
    write_reg(REG_WINDOW_LENGTH, LEN_WIDTH'(w));
    write_reg(REG_MIN_VALID, LEN_WIDTH'(mc));
    end_writes();
  endtask

  // Stop offering and wait for every predicted sum to come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random settings, then rows of random length with random content
  task automatic random_phase(input int n_items);
    int  w;
    int  mc;
    int  nan_mode;
    int  row_left;
    int  span;
    logic ok;
    logic first;
    bit  wrote;
    wrote = 0;
    case ($urandom_range(0, 9))
      0:       w = $urandom_range(0, 2047);
      1:       w = MAX_WINDOW;
      2, 3:    w = $urandom_range(9, 40);
      default: w = $urandom_range(1, 8);
    endcase
    span = span_of(w);
    case ($urandom_range(0, 5))
      0:       mc = $urandom_range(0, 2047);
      1:       mc = span + $urandom_range(1, 3);
      2:       mc = 0;
      default: mc = $urandom_range(1, span);
    endcase
    if ($urandom_range(0, 3) != 0) begin
      write_reg(REG_WINDOW_LENGTH, LEN_WIDTH'(w));
      wrote = 1;
    end
    if ($urandom_range(0, 3) != 0) begin
      write_reg(REG_MIN_VALID, LEN_WIDTH'(mc));
      wrote = 1;
    end
    if ($urandom_range(0, 5) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, LEN_WIDTH'($urandom));
      wrote = 1;
    end
    if (wrote) end_writes();
    span     = span_of(cur_win);
    nan_mode = $urandom_range(0, 2);
    row_left = 0;
    for (int i = 0; i < n_items; i++) begin
      first = (row_left == 0) || ($urandom_range(0, 19) == 0);
      if (row_left == 0) row_left = $urandom_range(1, 3 * span + 2);
      row_left--;
      case (nan_mode)
        0:       ok = 1'b1;
        1:       ok = ($urandom_range(0, 7) != 0);
        default: ok = $urandom_range(0, 1);
      endcase
      send_sample(pick_sample(), ok, first);
    end
    drain();
  endtask

  // Stimulus
  initial begin
    int n;
    int rand_items;
    in_valid     = 1'b0;
    sample       = '0;
    sample_valid = 1'b0;
    row_start    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_WINDOW_LENGTH;
    cfg_data     = '0;
    rst          = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: window of one, extremes, a row start and a missing sample
    send_sample(32'sh7fffffff, 1'b1, 1'b0);
    send_sample(32'sh80000000, 1'b1, 1'b0);
    send_sample(32'sd0, 1'b1, 1'b1);
    send_sample(32'sd123, 1'b0, 1'b0);
    send_sample(-32'sd1, 1'b1, 1'b0);
    drain();

    // window of three, two valid needed; eviction, missing samples, new row
    set_window(3, 2);
    send_sample(32'sd5, 1'b1, 1'b1);
    send_sample(32'sd7, 1'b1, 1'b0);
    send_sample(32'sh80000000, 1'b0, 1'b0);
    send_sample(32'sd10, 1'b1, 1'b0);
    send_sample(32'sh7fffffff, 1'b1, 1'b0);
    send_sample(32'sd1, 1'b0, 1'b1);
    send_sample(32'sd2, 1'b1, 1'b0);
    send_sample(32'sd3, 1'b1, 1'b0);
    drain();

    // zero window and zero min count act as one
    set_window(0, 0);
    send_sample(32'sd9, 1'b1, 1'b0);
    send_sample(32'sd4, 1'b0, 1'b0);
    send_sample(-32'sd4, 1'b1, 1'b0);
    drain();

    // min count above the window never flags valid; spare index ignored
    write_reg(REG_WINDOW_LENGTH, LEN_WIDTH'(2));
    write_reg(REG_MIN_VALID, LEN_WIDTH'(3));
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '1);
    end_writes();
    send_sample(32'sd11, 1'b1, 1'b1);
    send_sample(32'sd12, 1'b1, 1'b0);
    send_sample(32'sd13, 1'b1, 1'b0);
    drain();

    // long result hold-off with a steady sender so the block backs up
    set_window(5, 2);
    src_gaps = 0;
    hold_req = 1;
    for (int i = 0; i < 60; i++)
      send_sample(pick_sample(), $urandom_range(0, 3) != 0, (i % 17) == 0);
    drain();
    src_gaps = 1;

    // oversized window clamps to the full ring; one missing sample late on
    set_window(2047, 25);
    for (int i = 0; i < 30; i++)
      send_sample($urandom, i != 20, i == 0);
    drain();

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      n = $urandom_range(20, 60);
      random_phase(n);
      rand_items += n;
    end

    // closing stretch at full rate on both sides
    src_gaps   = 0;
    snk_stalls = 0;
    random_phase(40);

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[moving_window_sum_nan_skip] OK");
    end else begin
      $display("[moving_window_sum_nan_skip] ERROR");
    end
    $finish;
  end

endmodule
